>>> design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> design/hdc_pkg.sv
// Shared constants, types and codes of the hypervector encoder.
package hdc_pkg;

  localparam int HV_WORDS      = 16;
  localparam int LEVELS        = 255;
  localparam int CHANNEL_COUNT = 8;

  localparam int WORD_BITS   = 64;
  localparam int WORD_W      = (HV_WORDS > 1) ? $clog2(HV_WORDS) : 1;
  localparam int CH_W        = 3;
  localparam int WIDX_W      = 4;
  localparam int SAMPLE_W    = 16;
  localparam int OUT_INDEX_W = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int BASIS_DEPTH = CHANNEL_COUNT * HV_WORDS;
  localparam int BASIS_AW    = (BASIS_DEPTH > 1) ? $clog2(BASIS_DEPTH) : 1;

  // Level is below LEVELS, so it fits eight bits; one quotient bit per step.
  localparam int QUO_W  = 8;
  localparam int STEP_W = 3;
  localparam int NUM_W  = SAMPLE_W + QUO_W;
  localparam int LV_W   = (WORD_W + 7 > QUO_W) ? WORD_W + 7 : QUO_W + 1;

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 72;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_RESET = 16'd1023;
  localparam logic [SAMPLE_W-1:0] OFFSET_RESET     = 16'd0;
  localparam logic                BIND_RESET       = 1'b1;

  localparam logic KIND_BASIS  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_SCALE  = 2'd0,
    REG_OFFSET      = 2'd1,
    REG_BIND_ENABLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              wr_basis;
    logic              load_sample;
    logic              div_step;
    logic              bind_rd;
    logic              emit_load;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

>>> design/hdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hdc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/hdc_ctrl.sv
// Controller: sequences basis writes, division, binding pass and word emission.
module hdc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tuser,
  input  logic          s_tlast,
  output logic          s_tready,
  input  hdc_pkg::sts_t sts,
  output hdc_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_BIND  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                      state, state_next;
  logic [hdc_pkg::WORD_W-1:0]  word, word_next;
  logic [hdc_pkg::STEP_W-1:0]  step, step_next;
  logic                        last_q, last_next;
  logic                        accept;
  logic                        word_end;
  logic                        step_end;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign word_end = (word == hdc_pkg::WORD_W'(hdc_pkg::HV_WORDS - 1));
  assign step_end = (step == hdc_pkg::STEP_W'(hdc_pkg::QUO_W - 1));

  always_comb begin
    state_next      = state;
    word_next       = word;
    step_next       = step;
    last_next       = last_q;
    cmd.wr_basis    = 1'b0;
    cmd.load_sample = 1'b0;
    cmd.div_step    = 1'b0;
    cmd.bind_rd     = 1'b0;
    cmd.emit_load   = 1'b0;
    cmd.word        = word;
    unique case (state)
      S_IDLE: begin
        if (accept && s_tuser == hdc_pkg::KIND_BASIS) begin
          cmd.wr_basis = 1'b1;
        end else if (accept) begin
          cmd.load_sample = 1'b1;
          last_next       = s_tlast;
          step_next       = '0;
          state_next      = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step_end) begin
          word_next  = '0;
          state_next = S_BIND;
        end
      end
      S_BIND: begin
        // issue one basis read per cycle; the accumulator update follows from the registered read data
        cmd.bind_rd = 1'b1;
        word_next   = word + 1'b1;
        if (word_end) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        word_next  = '0;
        state_next = last_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          word_next     = word + 1'b1;
          if (word_end) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      word   <= '0;
      step   <= '0;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      word   <= word_next;
      step   <= step_next;
      last_q <= last_next;
    end
  end

endmodule

>>> design/hdc_datapath.sv
// Datapath: config registers, basis RAM, level divider, accumulator, output register.
module hdc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hdc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [hdc_pkg::CH_W-1:0]            in_channel,
  input  logic [hdc_pkg::WIDX_W-1:0]          in_word_index,
  input  logic [hdc_pkg::WORD_BITS-1:0]       in_basis_data,
  input  logic [hdc_pkg::SAMPLE_W-1:0]        in_sample_value,
  input  hdc_pkg::cmd_t                       cmd,
  output hdc_pkg::sts_t                       sts,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hdc_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                m_tlast
);

  logic [hdc_pkg::SAMPLE_W-1:0]  full_scale;
  logic [hdc_pkg::SAMPLE_W-1:0]  offset;
  logic                          bind_enable;

  logic [hdc_pkg::CH_W-1:0]      ch_q;
  logic                          all_q;
  logic                          bind_q;
  logic [hdc_pkg::NUM_W-1:0]     num_q;
  logic [hdc_pkg::NUM_W-1:0]     dsh_q;
  logic [hdc_pkg::QUO_W-1:0]     lvl_q;
  logic                          ge;

  logic [hdc_pkg::SAMPLE_W-1:0]  v;
  logic                          wr_ok;
  logic [hdc_pkg::BASIS_AW-1:0]  waddr;
  logic [hdc_pkg::BASIS_AW-1:0]  raddr;
  logic [hdc_pkg::WORD_BITS-1:0] rdata;

  logic                          upd_valid_q;
  logic [hdc_pkg::WORD_W-1:0]    upd_word_q;
  logic [hdc_pkg::WORD_BITS-1:0] acc [hdc_pkg::HV_WORDS];
  logic [hdc_pkg::WORD_W-1:0]    acc_addr;
  logic [hdc_pkg::WORD_BITS-1:0] acc_rd;
  logic [hdc_pkg::WORD_BITS-1:0] code;

  function automatic logic [hdc_pkg::WORD_BITS-1:0] thermo_word(
    input logic [hdc_pkg::QUO_W-1:0]  level,
    input logic                       all,
    input logic [hdc_pkg::WORD_W-1:0] w
  );
    logic [hdc_pkg::LV_W-1:0]      lo;
    logic [hdc_pkg::LV_W-1:0]      lvl;
    logic [hdc_pkg::LV_W-1:0]      diff;
    logic [hdc_pkg::WORD_BITS-1:0] res;
    lo   = hdc_pkg::LV_W'(w) << 6;
    lvl  = hdc_pkg::LV_W'(level);
    diff = lvl - lo;
    if (all || lvl >= lo + hdc_pkg::LV_W'(hdc_pkg::WORD_BITS)) begin
      res = '1;
    end else if (lvl <= lo) begin
      res = '0;
    end else begin
      res = ~({hdc_pkg::WORD_BITS{1'b1}} << diff[5:0]);
    end
    return res;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale  <= hdc_pkg::FULL_SCALE_RESET;
      offset      <= hdc_pkg::OFFSET_RESET;
      bind_enable <= hdc_pkg::BIND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hdc_pkg::REG_FULL_SCALE:  full_scale  <= cfg_data[hdc_pkg::SAMPLE_W-1:0];
        hdc_pkg::REG_OFFSET:      offset      <= cfg_data[hdc_pkg::SAMPLE_W-1:0];
        hdc_pkg::REG_BIND_ENABLE: bind_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // basis store
  assign wr_ok = cmd.wr_basis
              && (32'(in_channel) < hdc_pkg::CHANNEL_COUNT)
              && (32'(in_word_index) < hdc_pkg::HV_WORDS);
  assign waddr = hdc_pkg::BASIS_AW'(in_channel) * hdc_pkg::BASIS_AW'(hdc_pkg::HV_WORDS)
               + hdc_pkg::BASIS_AW'(in_word_index);
  assign raddr = hdc_pkg::BASIS_AW'(ch_q) * hdc_pkg::BASIS_AW'(hdc_pkg::HV_WORDS)
               + hdc_pkg::BASIS_AW'(cmd.word);

  hdc_ram #(
    .WIDTH (hdc_pkg::WORD_BITS),
    .DEPTH (hdc_pkg::BASIS_DEPTH)
  ) u_basis (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (waddr),
    .wdata (in_basis_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sample capture and restoring divide, one quotient bit per step
  assign v  = in_sample_value - offset;
  assign ge = (num_q >= dsh_q);

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      ch_q   <= in_channel;
      all_q  <= (v >= full_scale);
      bind_q <= bind_enable && (32'(in_channel) < hdc_pkg::CHANNEL_COUNT);
      num_q  <= hdc_pkg::NUM_W'(v) * hdc_pkg::NUM_W'(hdc_pkg::LEVELS);
      dsh_q  <= hdc_pkg::NUM_W'(full_scale) << (hdc_pkg::QUO_W - 1);
      lvl_q  <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        num_q <= num_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      lvl_q <= {lvl_q[hdc_pkg::QUO_W-2:0], ge};
    end
  end

  // accumulator: one port, update has priority over emission
  assign acc_addr = upd_valid_q ? upd_word_q : cmd.word;
  assign acc_rd   = acc[acc_addr];
  assign code     = thermo_word(lvl_q, all_q, upd_word_q)
                  ^ (bind_q ? rdata : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid_q <= 1'b0;
    end else begin
      upd_valid_q <= cmd.bind_rd;
    end
    upd_word_q <= cmd.word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hdc_pkg::HV_WORDS; i++) begin
        acc[i] <= '0;
      end
    end else if (upd_valid_q) begin
      acc[acc_addr] <= acc_rd | code;
    end else if (cmd.emit_load) begin
      acc[acc_addr] <= '0;
    end
  end

  // output register
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      m_tdata <= {{(hdc_pkg::M_TDATA_W - hdc_pkg::WORD_BITS - hdc_pkg::OUT_INDEX_W){1'b0}},
                  acc_rd, hdc_pkg::OUT_INDEX_W'(cmd.word)};
      m_tlast <= (cmd.word == hdc_pkg::WORD_W'(hdc_pkg::HV_WORDS - 1));
    end
  end

endmodule

>>> design/hdc_thermometer_bind_bundle_encoder.sv
// Hypervector encoder top level: thermometer code, XOR bind, OR bundle.
//
// Input stream (s_*): s_tuser is the item kind (0 basis word, 1 sample),
// s_tlast marks the sample that completes the hypervector. A basis item
// writes one 64-bit word of a channel's basis vector in its accept cycle.
// A sample is accepted, its level is found by an 8-step restoring divider
// (one quotient bit per cycle), then the 16 accumulator words are updated
// one per cycle through the basis RAM read port, then a drain state follows.
// A sample holds off further input until it is done; a basis write does not.
// After a sample marked last, the 16 accumulator words stream out on m_*,
// lowest first, m_tlast on the last; each word is cleared as it is loaded.
// The first word is loaded after the drain state, and input reopens once the
// last word has been loaded.
// Input is not taken while words remain to be loaded into the output
// register; a stalled receiver holds the word and stalls emission.
// Reset (rst, synchronous) clears the accumulator and control and sets the
// configuration registers to defaults; basis RAM contents are undefined until written.
// Configuration writes take effect at once; the user makes them only while idle, which the block does not enforce.
module hdc_thermometer_bind_bundle_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // channel[2:0], word_index[6:3], basis_data[70:7], sample_value[86:71], zero[87]
  input  logic [hdc_pkg::S_TDATA_W-1:0]     s_tdata,
  // kind
  input  logic                              s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_index[3:0], out_data[67:4], zero[71:68]
  output logic [hdc_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic                              m_tlast
);

  hdc_pkg::cmd_t cmd;
  hdc_pkg::sts_t sts;

  hdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_channel      (s_tdata[2:0]),
    .in_word_index   (s_tdata[6:3]),
    .in_basis_data   (s_tdata[70:7]),
    .in_sample_value (s_tdata[86:71]),
    .cmd             (cmd),
    .sts             (sts),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast)
  );

endmodule

>>> design/hdc_checker.sv
// Port-level checker for the hypervector encoder, bound to the top level.
`include "assert_macros.svh"

module hdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [hdc_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);

  // a stalled word holds
  `ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // no new item while a frame is still streaming out
  `ASSERT_IMPL(a_busy_emit, clk, rst, m_tvalid && !m_tlast, !s_tready)

  // words of a frame follow back to back in index order
  `ASSERT_NEXT(a_index_seq, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1))

  // the final word carries the top index
  `ASSERT_IMPL(a_last_index, clk, rst, m_tvalid && m_tlast, m_tdata[3:0] == 4'(hdc_pkg::HV_WORDS - 1))

endmodule

bind hdc_thermometer_bind_bundle_encoder hdc_checker u_hdc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
